// ===== src/cartridge_bank_switch_decoder_core_assert.svh =====
// Assertion macros used by the checker file of the bank switch decoder.
`ifndef CARTRIDGE_BANK_SWITCH_DECODER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_SWITCH_DECODER_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define CBSD_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define CBSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define CBSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cbsd_pkg.sv =====
// Types, constants and register write codes of the cartridge bank switch decoder.
package cbsd_pkg;

   localparam int PRG_SLOTS    = 4;
   localparam int CHR_SLOTS    = 8;
   localparam int PRG_BANK_W   = 10;
   localparam int CHR_BANK_W   = 11;
   localparam int ADDR_W       = 16;
   localparam int DATA_W       = 8;
   localparam int ROM_ADDR_W   = 23;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;
   localparam int PRG_SEL_W    = $clog2(PRG_SLOTS);
   localparam int CHR_SEL_W    = $clog2(CHR_SLOTS);

   typedef logic [PRG_BANK_W-1:0] prg_bank_type;
   typedef logic [CHR_BANK_W-1:0] chr_bank_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_PRG   = 2'd1,
      OP_CHR   = 2'd2
   } op_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_MASK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_MASK = 2'd1;

   // Bank register write addresses, exact match.
   localparam logic [ADDR_W-1:0] WR_PRG_32K    = 16'h8032;
   localparam logic [ADDR_W-1:0] WR_PRG_16K_LO = 16'h8416;
   localparam logic [ADDR_W-1:0] WR_PRG_16K_HI = 16'h8616;
   localparam logic [ADDR_W-1:0] WR_PRG_8K_0   = 16'h8408;
   localparam logic [ADDR_W-1:0] WR_PRG_8K_1   = 16'h8508;
   localparam logic [ADDR_W-1:0] WR_PRG_8K_2   = 16'h8608;
   localparam logic [ADDR_W-1:0] WR_PRG_8K_3   = 16'h8708;
   localparam logic [ADDR_W-1:0] WR_CHR_8K     = 16'h9008;
   localparam logic [ADDR_W-1:0] WR_CHR_4K_LO  = 16'h9004;
   localparam logic [ADDR_W-1:0] WR_CHR_4K_HI  = 16'h9404;
   // Single 1K pattern slots: 0x9001 + 0x100*n.
   localparam logic [ADDR_W-1:0] WR_CHR_1K_BASE = 16'h9001;
   localparam logic [ADDR_W-1:0] WR_CHR_1K_MASK = 16'hF8FF;

   // Bank table write beat handed from the pipeline to the slot table.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
   } bank_wr_type;

endpackage

// ===== src/cbsd_channels.sv =====
// Handshake channel interfaces of the cartridge bank switch decoder.
interface cbsd_req_if import cbsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;
   modport source (output valid, operation, address, data, input ready);
   modport sink   (input valid, operation, address, data, output ready);
endinterface

interface cbsd_rsp_if import cbsd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ROM_ADDR_W-1:0] rom_address;
   logic                  mapped;
   modport source (output valid, rom_address, mapped, input ready);
   modport sink   (input valid, rom_address, mapped, output ready);
endinterface

interface cbsd_csr_if import cbsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== src/cbsd_bank_table.sv =====
// Program and pattern slot bank table with write address decode.
module cbsd_bank_table import cbsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bank_wr_type  wr,
   output prg_bank_type prg_slot [PRG_SLOTS],
   output chr_bank_type chr_slot [CHR_SLOTS]
);

   prg_bank_type prg_ff [PRG_SLOTS];
   prg_bank_type prg_in [PRG_SLOTS];
   chr_bank_type chr_ff [CHR_SLOTS];
   chr_bank_type chr_in [CHR_SLOTS];

   always_comb begin
      prg_in = prg_ff;
      chr_in = chr_ff;
      if (wr.en) begin
         case (wr.address)
            WR_PRG_32K: begin
               for (int i = 0; i < PRG_SLOTS; i++)
                  prg_in[i] = {wr.data, PRG_SEL_W'(i)};
            end
            WR_PRG_16K_LO: begin
               for (int i = 0; i < 2; i++)
                  prg_in[i] = {1'b0, wr.data, 1'(i)};
            end
            WR_PRG_16K_HI: begin
               for (int i = 0; i < 2; i++)
                  prg_in[i+2] = {1'b0, wr.data, 1'(i)};
            end
            WR_PRG_8K_0: prg_in[0] = {2'b00, wr.data};
            WR_PRG_8K_1: prg_in[1] = {2'b00, wr.data};
            WR_PRG_8K_2: prg_in[2] = {2'b00, wr.data};
            WR_PRG_8K_3: prg_in[3] = {2'b00, wr.data};
            WR_CHR_8K: begin
               for (int i = 0; i < CHR_SLOTS; i++)
                  chr_in[i] = {wr.data, CHR_SEL_W'(i)};
            end
            WR_CHR_4K_LO: begin
               for (int i = 0; i < 4; i++)
                  chr_in[i] = {1'b0, wr.data, 2'(i)};
            end
            WR_CHR_4K_HI: begin
               for (int i = 0; i < 4; i++)
                  chr_in[i+4] = {1'b0, wr.data, 2'(i)};
            end
            default: begin
               // single 1K pattern slot, slot number in address bits 10:8
               if ((wr.address & WR_CHR_1K_MASK) == WR_CHR_1K_BASE)
                  chr_in[wr.address[8 +: CHR_SEL_W]] = {3'b000, wr.data};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PRG_SLOTS; i++)
            prg_ff[i] <= PRG_BANK_W'(i);
         for (int i = 0; i < CHR_SLOTS; i++)
            chr_ff[i] <= CHR_BANK_W'(i);
      end else begin
         prg_ff <= prg_in;
         chr_ff <= chr_in;
      end
   end

   assign prg_slot = prg_ff;
   assign chr_slot = chr_ff;

endmodule

// ===== src/cartridge_bank_switch_decoder_core.sv =====
// Top level of the cartridge bank switch decoder: beat pipeline and address translation.
//
//   channel  | dir | beat carries                     | accepted when
//   ---------+-----+----------------------------------+----------------------------
//   req_bus  | in  | operation, address, data         | req_bus.valid & ready
//   rsp_bus  | out | rom_address, mapped              | rsp_bus.valid & ready
//   csr_bus  | in  | index (0 prg mask, 1 chr mask)   | csr_bus.valid & ready (=1)
//
// One result beat for every request beat; a request beat passes the request register
// and then the result register before its result is offered.
// Throughput is one beat per cycle while the result side drains; the slot table read
// and mask are combinational between the request register and the result register.
// Reset (synchronous) maps program slots to banks 0-3, pattern slots to 0-7,
// and sets both masks to all ones.
// A stalled rsp holds its beat; the request register keeps accepting as long as
// the result register drains or is empty.
module cartridge_bank_switch_decoder_core import cbsd_pkg::*; (
   input logic          clock,
   input logic          reset,
   cbsd_req_if.sink     req_bus,
   cbsd_rsp_if.source   rsp_bus,
   cbsd_csr_if.sink     csr_bus
);

   // request stage
   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_op_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [DATA_W-1:0] s1_data_ff;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROM_ADDR_W-1:0] rom_ff, rom_in;
   logic                  mapped_ff, mapped_in;

   // size masks
   prg_bank_type prg_mask_ff, prg_mask_in;
   chr_bank_type chr_mask_ff, chr_mask_in;

   logic        s2_load;
   logic        s1_adv;
   logic        req_accept;
   op_type      s1_op;
   bank_wr_type table_wr;
   prg_bank_type prg_slot [PRG_SLOTS];
   chr_bank_type chr_slot [CHR_SLOTS];
   prg_bank_type prg_bank;
   chr_bank_type chr_bank;

   // Load the result register whenever it is empty or being drained.
   assign s2_load        = !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv         = s1_valid_ff && s2_load;
   assign req_bus.ready  = !s1_valid_ff || s2_load;
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign s1_op          = op_type'(s1_op_ff);

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;

   // Commit register writes as the beat leaves the request stage, in beat order.
   always_comb begin
      table_wr.en      = s1_adv && (s1_op == OP_WRITE);
      table_wr.address = s1_addr_ff;
      table_wr.data    = s1_data_ff;
   end

   cbsd_bank_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (table_wr),
      .prg_slot (prg_slot),
      .chr_slot (chr_slot)
   );

   // Translate: pick the slot by the window bits, mask by the ROM size.
   always_comb begin
      prg_bank  = prg_slot[s1_addr_ff[13 +: PRG_SEL_W]] & prg_mask_ff;
      chr_bank  = chr_slot[s1_addr_ff[10 +: CHR_SEL_W]] & chr_mask_ff;
      rom_in    = '0;
      mapped_in = 1'b0;
      case (s1_op)
         OP_PRG: begin
            if (s1_addr_ff[15]) begin
               rom_in    = {prg_bank, s1_addr_ff[12:0]};
               mapped_in = 1'b1;
            end
         end
         OP_CHR: begin
            if (s1_addr_ff[15:13] == 3'b000) begin
               rom_in    = {2'b00, chr_bank, s1_addr_ff[9:0]};
               mapped_in = 1'b1;
            end
         end
         default: begin
            // register writes and the unused code answer unmapped
            rom_in    = '0;
            mapped_in = 1'b0;
         end
      endcase
   end

   // Configuration: always ready, drop writes to indexes beyond the list.
   assign csr_bus.ready = 1'b1;
   always_comb begin
      prg_mask_in = prg_mask_ff;
      chr_mask_in = chr_mask_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PRG_MASK: prg_mask_in = csr_bus.wdata[PRG_BANK_W-1:0];
            CSR_CHR_MASK: chr_mask_in = csr_bus.wdata[CHR_BANK_W-1:0];
            default: begin
               prg_mask_in = prg_mask_ff;
               chr_mask_in = chr_mask_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prg_mask_ff  <= '1;
         chr_mask_ff  <= '1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prg_mask_ff  <= prg_mask_in;
         chr_mask_ff  <= chr_mask_in;
      end
   end

   // Payload registers: capture on accept or load, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req_bus.operation;
         s1_addr_ff <= req_bus.address;
         s1_data_ff <= req_bus.data;
      end
      if (s2_load) begin
         rom_ff    <= rom_in;
         mapped_ff <= mapped_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rom_address = rom_ff;
   assign rsp_bus.mapped      = mapped_ff;

endmodule

// ===== src/cbsd_checker.sv =====
// Port level checker of the cartridge bank switch decoder and its bind.
`include "cartridge_bank_switch_decoder_core_assert.svh"

module cbsd_checker import cbsd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ROM_ADDR_W-1:0] rsp_rom_address,
   input logic                  rsp_mapped
);

   `CBSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_rom_address) && $stable(rsp_mapped),
      "stalled result beat changed")
   `CBSD_ASSERT_SAME(a_unmapped_zero, clock, reset, rsp_valid && !rsp_mapped,
      rsp_rom_address == '0, "unmapped result has nonzero address")
   `CBSD_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid,
      "result beat right after reset")
   `CBSD_ASSERT_SAME(a_ready_when_drained, clock, reset, !rsp_valid || rsp_ready,
      req_ready, "request stalled while result side drains")

endmodule

bind cartridge_bank_switch_decoder_core cbsd_checker u_cbsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_rom_address (rsp_bus.rom_address),
   .rsp_mapped      (rsp_bus.mapped)
);

// ===== tb/sv/cbsd_tb_pkg.sv =====
// Scoreboard class that predicts bank lookups and checks the result beats.
package cbsd_tb_pkg;
   import cbsd_pkg::*;

   typedef struct {
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  mapped;
   } lookup_type;

   class bank_lookup_scoreboard;
      prg_bank_type prg_bank [PRG_SLOTS];
      chr_bank_type chr_bank [CHR_SLOTS];
      prg_bank_type prg_mask;
      chr_bank_type chr_mask;
      lookup_type   lookup_q [$];
      int unsigned  errors;
      int unsigned  results_checked;

      function new();
         for (int i = 0; i < PRG_SLOTS; i++) prg_bank[i] = prg_bank_type'(i);
         for (int i = 0; i < CHR_SLOTS; i++) chr_bank[i] = chr_bank_type'(i);
         prg_mask        = '1;
         chr_mask        = '1;
         errors          = 0;
         results_checked = 0;
      endfunction

      function int unsigned pending();
         return lookup_q.size();
      endfunction

      function void write_mask(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_PRG_MASK: prg_mask = value[PRG_BANK_W-1:0];
            CSR_CHR_MASK: chr_mask = value[CHR_BANK_W-1:0];
            default: ;
         endcase
      endfunction

      function void fill_prg(int first, int count, int base);
         for (int i = 0; i < count; i++)
            prg_bank[(first + i) % PRG_SLOTS] = prg_bank_type'(base + i);
      endfunction

      function void fill_chr(int first, int count, int base);
         for (int i = 0; i < count; i++)
            chr_bank[(first + i) % CHR_SLOTS] = chr_bank_type'(base + i);
      endfunction

      function void load_banks(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
         int base;
         base = int'(d);
         case (a)
            WR_PRG_32K:    fill_prg(0, 4, base * 4);
            WR_PRG_16K_LO: fill_prg(0, 2, base * 2);
            WR_PRG_16K_HI: fill_prg(2, 2, base * 2);
            WR_PRG_8K_0:   fill_prg(0, 1, base);
            WR_PRG_8K_1:   fill_prg(1, 1, base);
            WR_PRG_8K_2:   fill_prg(2, 1, base);
            WR_PRG_8K_3:   fill_prg(3, 1, base);
            WR_CHR_8K:     fill_chr(0, 8, base * 8);
            WR_CHR_4K_LO:  fill_chr(0, 4, base * 4);
            WR_CHR_4K_HI:  fill_chr(4, 4, base * 4);
            default: begin
               if ((a & WR_CHR_1K_MASK) == WR_CHR_1K_BASE)
                  fill_chr(int'(a[10:8]), 1, base);
            end
         endcase
      endfunction

      // Apply one accepted access beat and queue the lookup it must produce.
      function void note_access(logic [1:0] op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
         lookup_type   exp_lookup;
         prg_bank_type pb;
         chr_bank_type cb;
         exp_lookup.rom_address = '0;
         exp_lookup.mapped      = 1'b0;
         case (op)
            OP_WRITE: load_banks(a, d);
            OP_PRG: begin
               if (a[15]) begin
                  pb = prg_bank[a[14:13]] & prg_mask;
                  exp_lookup.rom_address = {pb, a[12:0]};
                  exp_lookup.mapped      = 1'b1;
               end
            end
            OP_CHR: begin
               if (a < 16'h2000) begin
                  cb = chr_bank[a[12:10]] & chr_mask;
                  exp_lookup.rom_address = ROM_ADDR_W'({cb, a[9:0]});
                  exp_lookup.mapped      = 1'b1;
               end
            end
            default: ;
         endcase
         lookup_q.push_back(exp_lookup);
      endfunction

      function void check_lookup(logic [ROM_ADDR_W-1:0] rom_address, logic mapped);
         lookup_type exp_lookup;
         if (lookup_q.size() == 0) begin
            $error("result beat with no access waiting: rom_address %h mapped %b",
                   rom_address, mapped);
            errors++;
            return;
         end
         exp_lookup = lookup_q.pop_front();
         results_checked++;
         if (rom_address !== exp_lookup.rom_address) begin
            $error("rom_address expected %h actual %h", exp_lookup.rom_address, rom_address);
            errors++;
         end
         if (mapped !== exp_lookup.mapped) begin
            $error("mapped expected %b actual %b", exp_lookup.mapped, mapped);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top testbench of the cartridge bank switch decoder: stimulus, handshakes and final verdict.
module tb_top;
   import cbsd_pkg::*;
   import cbsd_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Operation code that the enum leaves out; the block must answer it unmapped.
   localparam logic [1:0] OP_NONE = 2'd3;
   // Register indexes past the end of the list; writes to them change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 325;
   // Result count at which the receiver starts its long hold-off.
   localparam int PRESSURE_AT     = 150;
   localparam int PRESSURE_CYCLES = 300;

   localparam logic [ADDR_W-1:0] BANK_PORTS [10] = '{
      WR_PRG_32K, WR_PRG_16K_LO, WR_PRG_16K_HI, WR_PRG_8K_0, WR_PRG_8K_1,
      WR_PRG_8K_2, WR_PRG_8K_3, WR_CHR_8K, WR_CHR_4K_LO, WR_CHR_4K_HI
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbsd_req_if req_bus ();
   cbsd_rsp_if rsp_bus ();
   cbsd_csr_if csr_bus ();

   bank_lookup_scoreboard sb = new();

   cartridge_bank_switch_decoder_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hold every block input at a known value from time zero.
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_WRITE;
      req_bus.address   = '0;
      req_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_PRG_MASK;
      csr_bus.wdata     = '0;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sample all three channels at the rising edge: register writes first, then
   // the access beat, then the result beat, so a step's order never matters.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.write_mask(csr_bus.index, csr_bus.wdata);
         if (req_bus.valid && req_bus.ready)
            sb.note_access(req_bus.operation, req_bus.address, req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_lookup(rsp_bus.rom_address, rsp_bus.mapped);
      end
   end

   // Receiver: random runs of ready with stalls between them, plus one long
   // hold-off that lets the pipeline fill and push back on the sender.
   initial begin
      int unsigned hold_cycles;
      int unsigned open_cycles;
      bit          pressure_done;
      hold_cycles   = 0;
      open_cycles   = 0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && sb.results_checked >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_cycles   = PRESSURE_CYCLES;
         end
         if (hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (open_cycles != 0) begin
               open_cycles--;
            end else begin
               // Now and then leave ready up for a long stretch.
               open_cycles = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                                          : $urandom_range(1, 8);
               hold_cycles = gap_length();
            end
         end
      end
   end

   // Offer one access beat and hold it until the block takes it; leave valid
   // up so a back-to-back beat follows without a bubble.
   task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.address   <= a;
      req_bus.data      <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Drop the access channel and wait until every queued lookup has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // One random access: mostly bank loads at the decoded ports and lookups
   // inside the banked windows, the rest near misses, stray addresses and
   // the unused operation code.
   task automatic random_access();
      int unsigned           r;
      logic [1:0]            op;
      logic [ADDR_W-1:0]     a;
      logic [DATA_W-1:0]     d;
      r = $urandom_range(0, 99);
      d = DATA_W'($urandom);
      if (r < 35) begin
         op = OP_WRITE;
         case ($urandom_range(0, 13))
            10, 11: a = WR_CHR_1K_BASE | (ADDR_W'($urandom_range(0, 7)) << 8);
            12:     a = ADDR_W'($urandom);
            13:     a = BANK_PORTS[$urandom_range(0, 9)] ^ (16'h1 << $urandom_range(0, 15));
            default: a = BANK_PORTS[$urandom_range(0, 9)];
         endcase
      end else if (r < 65) begin
         op = OP_PRG;
         a  = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                          : {1'b1, 15'($urandom)};
      end else if (r < 95) begin
         op = OP_CHR;
         a  = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                          : {3'b000, 13'($urandom)};
      end else begin
         op = OP_NONE;
         a  = ADDR_W'($urandom);
      end
      send_access(op, a, d);
   endtask

   // Main sequence: reset, directed corners at reset masks, then random
   // phases each under a fresh pair of mask settings.
   initial begin
      int unsigned gap;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset mapping at the window edges, and the unmapped sides.
      send_access(OP_PRG,   16'h8000, 8'h00);
      send_access(OP_PRG,   16'hFFFF, 8'hFF);
      send_access(OP_PRG,   16'h7FFF, 8'h00);
      send_access(OP_CHR,   16'h0000, 8'hFF);
      send_access(OP_CHR,   16'h1FFF, 8'h00);
      send_access(OP_CHR,   16'h2000, 8'hFF);
      send_access(OP_NONE,  16'hFFFF, 8'hFF);
      // Every program granularity, with a lookup after the first load and after the last.
      send_access(OP_WRITE, WR_PRG_32K,    8'hFF);
      send_access(OP_PRG,   16'hE123,      8'h00);
      send_access(OP_WRITE, WR_PRG_16K_LO, 8'hAA);
      send_access(OP_WRITE, WR_PRG_16K_HI, 8'h55);
      send_access(OP_WRITE, WR_PRG_8K_0,   8'h00);
      send_access(OP_WRITE, WR_PRG_8K_1,   8'h80);
      send_access(OP_WRITE, WR_PRG_8K_2,   8'h7F);
      send_access(OP_WRITE, WR_PRG_8K_3,   8'hFF);
      send_access(OP_PRG,   16'hA000,      8'h00);
      // Every pattern granularity, the first and last 1K port, and a port
      // that only looks like one and must be ignored.
      send_access(OP_WRITE, WR_CHR_8K,     8'hFF);
      send_access(OP_WRITE, WR_CHR_4K_LO,  8'h12);
      send_access(OP_WRITE, WR_CHR_4K_HI,  8'hFE);
      send_access(OP_WRITE, WR_CHR_1K_BASE, 8'h01);
      send_access(OP_WRITE, WR_CHR_1K_BASE | 16'h0700, 8'hFF);
      send_access(OP_WRITE, 16'h9801,      8'hAB);
      send_access(OP_CHR,   16'h1C00,      8'h00);
      send_access(OP_CHR,   16'h0400,      8'h00);
      send_access(OP_PRG,   16'h0000,      8'hFF);

      for (int p = 0; p < PHASES; p++) begin
         // Touch the masks only with the pipeline empty.
         wait_drained();
         case (p)
            0: begin
               write_register(CSR_PRG_MASK, 11'h3FF);
               write_register(CSR_CHR_MASK, 11'h7FF);
               write_register(CSR_SPARE_2, CSR_DATA_W'($urandom));
            end
            1: begin
               write_register(CSR_PRG_MASK, 11'h000);
               write_register(CSR_CHR_MASK, 11'h000);
            end
            2: begin
               write_register(CSR_PRG_MASK, 11'h00F);
               write_register(CSR_CHR_MASK, 11'h07F);
               write_register(CSR_SPARE_3, CSR_DATA_W'($urandom));
            end
            4: begin
               // Set the unused top bit on the program mask as well.
               write_register(CSR_PRG_MASK, 11'h7FF);
               write_register(CSR_CHR_MASK, 11'h0FF);
            end
            default: begin
               write_register(CSR_PRG_MASK, CSR_DATA_W'($urandom_range(0, 2047)));
               write_register(CSR_CHR_MASK, CSR_DATA_W'($urandom_range(0, 2047)));
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            random_access();
            // Run the first part of each hundred back to back.
            gap = (i % 100 < 30) ? 0 : gap_length();
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      wait_drained();
      // Give a stray late beat time to show up.
      repeat (4) @(posedge clock);
      if (sb.pending() != 0)
         $error("%0d lookups never came back", sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run well past the slowest legal one.
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
